// File: rtl/hsd_pkg.sv
`timescale 1ns / 1ps

package hsd_pkg;

  // Number of candidate codewords and the width of a codeword index.
  localparam int unsigned NumCw   = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CwBits  = 8;
  localparam int unsigned GroupSz = 4;
  localparam int unsigned NumGrp  = NumCw / GroupSz;

  // Code rate limits and the rates with special handling.
  localparam logic [2:0] RateMin    = 3'd1;
  localparam logic [2:0] RateMax    = 3'd4;
  localparam logic [2:0] RateParity = 3'd1;
  localparam logic [2:0] RateHam74  = 3'd3;
  localparam logic [2:0] RateHam84  = 3'd4;

  // Syndromes that point at a data bit.
  localparam logic [2:0] SynBit0 = 3'd5;
  localparam logic [2:0] SynBit1 = 3'd7;
  localparam logic [2:0] SynBit2 = 3'd3;
  localparam logic [2:0] SynBit3 = 3'd6;

  // Codeword tables, codeword bit j is table bit (7 - j).
  localparam logic [CwBits-1:0] HammingTbl [NumCw] = '{
    8'd0, 8'd23, 8'd45, 8'd58, 8'd78, 8'd89, 8'd99, 8'd116,
    8'd139, 8'd156, 8'd166, 8'd177, 8'd197, 8'd210, 8'd232, 8'd255
  };
  localparam logic [CwBits-1:0] ParityTbl [NumCw] = '{
    8'd0, 8'd24, 8'd40, 8'd48, 8'd72, 8'd80, 8'd96, 8'd120,
    8'd136, 8'd144, 8'd160, 8'd184, 8'd192, 8'd216, 8'd232, 8'd240
  };

  // Side information that travels down the pipeline next to the scores.
  typedef struct packed {
    logic       soft_sel;
    logic [3:0] hard_nib;
  } side_t;

  // Reverses the order of the four bits of a nibble.
  function automatic logic [3:0] reverse4(input logic [3:0] v);
    reverse4 = {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

// File: rtl/hamming_soft_hard_decoder.sv
`timescale 1ns / 1ps

// Hamming codeword decoder, hard syndrome or soft maximum-likelihood.
// Input channel (in_valid_i / in_ready_o) carries one codeword per item: the
// code rate, the hard codeword byte and eight LLRs. Output channel
// (out_valid_o / out_ready_i) returns one data nibble per item, in order.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes soft_enable;
// it is always ready and must only be written while the block is idle.
// Sixteen scoring lanes correlate the LLRs with every candidate codeword;
// the merge stage picks the first maximum. The hard result is decoded on entry
// and travels beside the scores.
// Each item passes the four register stages in order, two lane stages, one
// merge stage and the output register, and can be taken once it lands in the
// output register.
// Throughput is one item per cycle; the four-stage pipeline advances as a
// whole while the output register is empty or being taken.
// When the receiver stalls, the whole pipeline holds and in_ready_o falls
// until the waiting result is taken.
// Reset clears all valid flags and sets soft_enable to 0 (hard decoding).
module hamming_soft_hard_decoder #(
  parameter int unsigned LLR_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_soft_enable_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  code_rate_i,
  input  logic [7:0]                  hard_codeword_i,
  input  logic signed [LLR_WIDTH-1:0] llr_0_i,
  input  logic signed [LLR_WIDTH-1:0] llr_1_i,
  input  logic signed [LLR_WIDTH-1:0] llr_2_i,
  input  logic signed [LLR_WIDTH-1:0] llr_3_i,
  input  logic signed [LLR_WIDTH-1:0] llr_4_i,
  input  logic signed [LLR_WIDTH-1:0] llr_5_i,
  input  logic signed [LLR_WIDTH-1:0] llr_6_i,
  input  logic signed [LLR_WIDTH-1:0] llr_7_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  dec_nibble_o
);

  localparam int unsigned ScoreW = LLR_WIDTH + 4;

  logic                        soft_enable_q;
  logic                        en;
  logic [2:0]                  rate;
  logic [3:0]                  len;
  logic [7:0]                  use_mask;
  logic [3:0]                  hard_nib;
  logic signed [LLR_WIDTH-1:0] llr [8];
  logic signed [ScoreW-1:0]    scores [hsd_pkg::NumCw];
  logic [hsd_pkg::IdxW-1:0]    win_idx;
  logic [2:0]                  vld_q;
  hsd_pkg::side_t              side_q [3];
  logic                        out_valid_q;
  logic [3:0]                  dec_nibble_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      soft_enable_q <= cfg_soft_enable_i;
    end
  end

  // The pipeline moves while the output register is empty or being taken.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Saturate the rate and build the mask of codeword bits in use.
  always_comb begin
    if (code_rate_i < hsd_pkg::RateMin) begin
      rate = hsd_pkg::RateMin;
    end else if (code_rate_i > hsd_pkg::RateMax) begin
      rate = hsd_pkg::RateMax;
    end else begin
      rate = code_rate_i;
    end
    len = {1'b0, rate} + 4'd4;
    for (int j = 0; j < 8; j++) begin
      use_mask[j] = 4'(j) < len;
    end
  end

  assign llr[0] = llr_0_i;
  assign llr[1] = llr_1_i;
  assign llr[2] = llr_2_i;
  assign llr[3] = llr_3_i;
  assign llr[4] = llr_4_i;
  assign llr[5] = llr_5_i;
  assign llr[6] = llr_6_i;
  assign llr[7] = llr_7_i;

  // Hard decoding of the incoming item.
  hsd_hard u_hard (
    .rate_i (rate),
    .word_i (hard_codeword_i),
    .nib_o  (hard_nib)
  );

  // One scoring lane per candidate codeword.
  for (genvar n = 0; n < hsd_pkg::NumCw; n++) begin : g_lane
    hsd_lane #(
      .LLR_WIDTH (LLR_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .llr_i     (llr),
      .pattern_i ((rate == hsd_pkg::RateParity) ? hsd_pkg::ParityTbl[n]
                                                : hsd_pkg::HammingTbl[n]),
      .use_i     (use_mask),
      .score_o   (scores[n])
    );
  end

  // Merge the lane scores.
  hsd_merge #(
    .SCORE_W (ScoreW)
  ) u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .scores_i (scores),
    .idx_o    (win_idx)
  );

  // Valid flags follow the items through the lane and merge stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[1:0], in_valid_i};
      out_valid_q <= vld_q[2];
    end
  end

  // Side information and the output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{soft_sel: soft_enable_q, hard_nib: hard_nib};
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
      dec_nibble_q <= side_q[2].soft_sel ? hsd_pkg::reverse4(win_idx)
                                         : side_q[2].hard_nib;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dec_nibble_o = dec_nibble_q;

  // A waiting result that is not taken blocks new items.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while a result is stalled");

  // A stall freezes the item positions in the pipeline.
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && out_valid_q)
    else $error("pipeline moved during a stall");

  // An item in the last stage reaches the output register when the pipe moves.
  a_last_stage_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[2] |=> out_valid_q)
    else $error("item lost between merge stage and output");

  // An accepted item enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item missing from first stage");

endmodule

// File: rtl/hsd_hard.sv
`timescale 1ns / 1ps

// Hard syndrome decoder: reads the codeword MSB-first, can fix one data bit at Hamming rates.
module hsd_hard (
  input  logic [2:0] rate_i,
  input  logic [7:0] word_i,
  output logic [3:0] nib_o
);

  logic [7:0] c;
  logic [3:0] len;
  logic       correct;
  logic [2:0] syn;
  logic [3:0] nib;

  // Unpack the codeword bits, first bit at the top of the right-aligned field.
  always_comb begin
    len = {1'b0, rate_i} + 4'd4;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) begin
        c[i] = word_i[3'(len - 4'd1 - 4'(i))];
      end else begin
        c[i] = 1'b0;
      end
    end
  end

  // Syndrome and single-bit correction of the data field.
  always_comb begin
    correct = 1'b0;
    if (rate_i == hsd_pkg::RateHam74) begin
      correct = 1'b1;
    end else if (rate_i == hsd_pkg::RateHam84) begin
      correct = ^c;
    end
    syn[0] = c[0] ^ c[1] ^ c[2] ^ c[4];
    syn[1] = c[1] ^ c[2] ^ c[3] ^ c[5];
    syn[2] = c[0] ^ c[1] ^ c[3] ^ c[6];
    nib = c[3:0];
    if (correct) begin
      case (syn)
        hsd_pkg::SynBit0: nib = nib ^ 4'b0001;
        hsd_pkg::SynBit1: nib = nib ^ 4'b0010;
        hsd_pkg::SynBit2: nib = nib ^ 4'b0100;
        hsd_pkg::SynBit3: nib = nib ^ 4'b1000;
        default: nib = c[3:0];
      endcase
    end
  end

  assign nib_o = nib;

endmodule

// File: rtl/hsd_lane.sv
`timescale 1ns / 1ps

// One scoring lane: correlates the LLRs with one candidate codeword.
module hsd_lane #(
  parameter int unsigned LLR_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [LLR_WIDTH-1:0] llr_i [8],
  input  logic [7:0]                  pattern_i,
  input  logic [7:0]                  use_i,
  output logic signed [LLR_WIDTH+3:0] score_o
);

  localparam int unsigned TermW = LLR_WIDTH + 1;
  localparam int unsigned PartW = LLR_WIDTH + 3;
  localparam int unsigned ScoreW = LLR_WIDTH + 4;

  logic signed [TermW-1:0]  term [8];
  logic signed [PartW-1:0]  lo_d, hi_d, lo_q, hi_q;
  logic signed [ScoreW-1:0] score_q;

  // Signed terms: plus the LLR for a one, minus it for a zero, nothing if unused.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (!use_i[j]) begin
        term[j] = '0;
      end else if (pattern_i[7-j]) begin
        term[j] = {llr_i[j][LLR_WIDTH-1], llr_i[j]};
      end else begin
        term[j] = -{llr_i[j][LLR_WIDTH-1], llr_i[j]};
      end
    end
    lo_d = '0;
    hi_d = '0;
    for (int j = 0; j < 4; j++) begin
      lo_d = lo_d + {{2{term[j][TermW-1]}}, term[j]};
      hi_d = hi_d + {{2{term[j+4][TermW-1]}}, term[j+4]};
    end
  end

  // Two half sums in the first stage, the full score in the second.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      score_q <= {lo_q[PartW-1], lo_q} + {hi_q[PartW-1], hi_q};
    end
  end

  assign score_o = score_q;

endmodule

// File: rtl/hsd_merge.sv
`timescale 1ns / 1ps

// Merging stage: finds the first maximum of all lane scores.
module hsd_merge #(
  parameter int unsigned SCORE_W = 20
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [SCORE_W-1:0] scores_i [hsd_pkg::NumCw],
  output logic [hsd_pkg::IdxW-1:0]  idx_o
);

  logic signed [SCORE_W-1:0]      grp_score_d [hsd_pkg::NumGrp];
  logic [hsd_pkg::IdxW-1:0]       grp_idx_d   [hsd_pkg::NumGrp];
  logic signed [SCORE_W-1:0]      grp_score_q [hsd_pkg::NumGrp];
  logic [hsd_pkg::IdxW-1:0]       grp_idx_q   [hsd_pkg::NumGrp];
  logic signed [SCORE_W-1:0]      best;
  logic [hsd_pkg::IdxW-1:0]       best_idx;

  // First level: winner of each group of four, lower index kept on a tie.
  always_comb begin
    for (int g = 0; g < hsd_pkg::NumGrp; g++) begin
      grp_score_d[g] = scores_i[g*hsd_pkg::GroupSz];
      grp_idx_d[g]   = hsd_pkg::IdxW'(g*hsd_pkg::GroupSz);
      for (int k = 1; k < hsd_pkg::GroupSz; k++) begin
        if (scores_i[g*hsd_pkg::GroupSz+k] > grp_score_d[g]) begin
          grp_score_d[g] = scores_i[g*hsd_pkg::GroupSz+k];
          grp_idx_d[g]   = hsd_pkg::IdxW'(g*hsd_pkg::GroupSz+k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_score_q <= grp_score_d;
      grp_idx_q   <= grp_idx_d;
    end
  end

  // Second level: winner among the group winners.
  always_comb begin
    best     = grp_score_q[0];
    best_idx = grp_idx_q[0];
    for (int g = 1; g < hsd_pkg::NumGrp; g++) begin
      if (grp_score_q[g] > best) begin
        best     = grp_score_q[g];
        best_idx = grp_idx_q[g];
      end
    end
  end

  assign idx_o = best_idx;

endmodule
